// ===== rtl/core/sha1_stream_hasher_macros.svh =====
// Assertion macros for the SHA-1 stream hasher; empty bodies when SYNTHESIS is set.
`ifndef SHA1_STREAM_HASHER_MACROS_SVH
`define SHA1_STREAM_HASHER_MACROS_SVH
`ifndef SYNTHESIS
// Flag a condition that must never hold outside reset.
`define SHA1S_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("sha1 stream hasher: forbidden condition seen");
// Require a consequence in the cycle after an antecedent.
`define SHA1S_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha1 stream hasher: expected follow-up missing");
`else
`define SHA1S_ASSERT_NEVER(label, clk, rst, cond)
`define SHA1S_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/sha1s_pkg.sv =====
// Shared types, constants and round helpers for the SHA-1 stream hasher.
package sha1s_pkg;

  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned ROUND_W     = 7;
  localparam int unsigned WORDS       = 5;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned COUNT_W     = 61;
  localparam int unsigned SCHED_DEPTH = 16;

  localparam logic [ROUND_W-1:0] ROUND_LAST   = ROUND_W'(ROUNDS - 1);
  localparam logic [ROUND_W-1:0] ROUND_P1_END = ROUND_W'(20);
  localparam logic [ROUND_W-1:0] ROUND_P2_END = ROUND_W'(40);
  localparam logic [ROUND_W-1:0] ROUND_P3_END = ROUND_W'(60);

  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(63);
  localparam logic [POS_W-1:0] POS_LEN     = POS_W'(56);
  localparam logic [IDX_W-1:0] WORD_LAST   = IDX_W'(WORDS - 1);

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  localparam logic [31:0] K1 = 32'h5a827999;
  localparam logic [31:0] K2 = 32'h6ed9eba1;
  localparam logic [31:0] K3 = 32'h8f1bbcdc;
  localparam logic [31:0] K4 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Source of a byte pushed into the block
  typedef enum logic [1:0] {
    SEL_INPUT,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } sha1s_sel_t;

  // Round group: choose function and constant
  typedef enum logic [1:0] {
    PH_CH,
    PH_PARITY1,
    PH_MAJ,
    PH_PARITY2
  } sha1s_phase_t;

  typedef struct packed {
    logic              push;
    sha1s_sel_t        sel;
    logic              latch_len;
    logic              start;
    logic              round_en;
    sha1s_phase_t      phase;
    logic              add;
    logic              clear;
    logic [IDX_W-1:0]  word_sel;
  } sha1s_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
  } sha1s_status_t;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

endpackage

// ===== rtl/core/sha1_stream_hasher.sv =====
// Top level of the SHA-1 stream hasher: sequencer plus datapath.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+-----------------------------------------
//  input   | item_valid   | item_ready   | data_byte, byte_valid, end_of_message
//  digest  | digest_valid | digest_ready | digest_word, word_index, last_word
//
// A beat that carries a byte and does not fill the block keeps item_ready high.
// The 64th byte of a block starts the compression: 80 rounds on the single shared
// round unit, then a step that folds the working words into the chain.
// An end beat adds padding one byte per cycle while no block compresses, plus a
// step into the length field (up to 72 bytes, with one or two compressions) and
// then five digest beats, one per cycle when taken.
// Reset loads the initial chain values and a zero byte count; no clearing pass.
// item_ready stays low while padding, compressing or presenting the digest.
`include "sha1_stream_hasher_macros.svh"

module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1s_pkg::*;

  sha1s_cmd_t    cmd;
  sha1s_status_t status;

  // Sequencer: walks load, padding, rounds and digest beats
  sha1s_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .digest_valid   (digest_valid),
    .digest_ready   (digest_ready),
    .word_index     (word_index),
    .last_word      (last_word),
    .status         (status),
    .cmd            (cmd)
  );

  // Datapath: byte packing, schedule window, round unit and chain words
  sha1s_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .status      (status),
    .digest_word (digest_word)
  );

  // Input and digest sides never open at the same time
  `SHA1S_ASSERT_NEVER(a_no_overlap, clk, rst, item_ready && digest_valid)
  // A taken non-final digest beat is followed by another
  `SHA1S_ASSERT_NEXT(a_digest_runs, clk, rst, digest_valid && digest_ready && !last_word, digest_valid)
  // After the final digest beat the input side reopens
  `SHA1S_ASSERT_NEXT(a_reopen, clk, rst, digest_valid && digest_ready && last_word, item_ready)

endmodule

// ===== rtl/core/sha1s_ctrl.sv =====
// Sequencer for the SHA-1 stream hasher: loading, padding, rounds and digest beats.
module sha1s_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  byte_valid,
  input  logic                  end_of_message,
  output logic                  digest_valid,
  input  logic                  digest_ready,
  output logic [2:0]            word_index,
  output logic                  last_word,
  input  sha1s_pkg::sha1s_status_t status,
  output sha1s_pkg::sha1s_cmd_t    cmd
);
  import sha1s_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD80 = 3'd1;
  localparam logic [2:0] S_PADZ  = 3'd2;
  localparam logic [2:0] S_PADL  = 3'd3;
  localparam logic [2:0] S_COMP  = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]         state, state_next;
  logic [2:0]         after, after_next;
  logic [ROUND_W-1:0] round, round_next;
  logic [IDX_W-1:0]   widx, widx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      after <= S_IDLE;
      round <= '0;
      widx  <= '0;
    end else begin
      state <= state_next;
      after <= after_next;
      round <= round_next;
      widx  <= widx_next;
    end
  end

  always_comb begin
    state_next   = state;
    after_next   = after;
    round_next   = round;
    widx_next    = widx;
    cmd          = '0;
    cmd.sel      = SEL_INPUT;
    cmd.word_sel = widx;
    if (round < ROUND_P1_END) begin
      cmd.phase = PH_CH;
    end else if (round < ROUND_P2_END) begin
      cmd.phase = PH_PARITY1;
    end else if (round < ROUND_P3_END) begin
      cmd.phase = PH_MAJ;
    end else begin
      cmd.phase = PH_PARITY2;
    end

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (byte_valid) begin
            cmd.push = 1'b1;
            if (status.pos == POS_LAST) begin
              cmd.start  = 1'b1;
              state_next = S_COMP;
              after_next = end_of_message ? S_PAD80 : S_IDLE;
            end else if (end_of_message) begin
              state_next = S_PAD80;
            end
          end else if (end_of_message) begin
            state_next = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.latch_len = 1'b1;
        cmd.push      = 1'b1;
        cmd.sel       = SEL_PAD;
        state_next    = S_PADZ;
        if (status.pos == POS_LAST) begin
          cmd.start  = 1'b1;
          state_next = S_COMP;
          after_next = S_PADZ;
        end
      end
      S_PADZ: begin
        if (status.pos == POS_LEN) begin
          state_next = S_PADL;
        end else begin
          cmd.push = 1'b1;
          cmd.sel  = SEL_ZERO;
          if (status.pos == POS_LAST) begin
            cmd.start  = 1'b1;
            state_next = S_COMP;
            after_next = S_PADZ;
          end
        end
      end
      S_PADL: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_LEN;
        if (status.pos == POS_LAST) begin
          cmd.start  = 1'b1;
          state_next = S_COMP;
          after_next = S_OUT;
        end
      end
      S_COMP: begin
        cmd.round_en = 1'b1;
        round_next   = round + 1'b1;
        if (round == ROUND_LAST) begin
          round_next = '0;
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = after;
      end
      S_OUT: begin
        if (digest_ready) begin
          if (widx == WORD_LAST) begin
            cmd.clear  = 1'b1;
            widx_next  = '0;
            state_next = S_IDLE;
          end else begin
            widx_next = widx + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign item_ready   = (state == S_IDLE);
  assign digest_valid = (state == S_OUT);
  assign word_index   = widx;
  assign last_word    = (widx == WORD_LAST);

endmodule

// ===== rtl/core/sha1s_dp.sv =====
// Datapath for the SHA-1 stream hasher: byte packing, schedule window, rounds, chain.
module sha1s_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [7:0]              data_byte,
  input  sha1s_pkg::sha1s_cmd_t   cmd,
  output sha1s_pkg::sha1s_status_t status,
  output logic [31:0]             digest_word
);
  import sha1s_pkg::*;

  logic [COUNT_W-1:0] byte_count;
  logic [23:0]        acc;
  logic [63:0]        len;
  logic [31:0]        win [SCHED_DEPTH];
  logic [31:0]        h [WORDS];
  logic [31:0]        a, b, c, d, e;
  logic [7:0]         pb;
  logic [31:0]        f, k, t, w_new;

  always_comb begin
    unique case (cmd.sel)
      SEL_INPUT: pb = data_byte;
      SEL_PAD:   pb = PAD_BYTE;
      SEL_ZERO:  pb = 8'h00;
      SEL_LEN:   pb = len[63:56];
      default:   pb = 8'h00;
    endcase
  end

  always_comb begin
    unique case (cmd.phase)
      PH_CH: begin
        f = (b & c) | (~b & d);
        k = K1;
      end
      PH_PARITY1: begin
        f = b ^ c ^ d;
        k = K2;
      end
      PH_MAJ: begin
        f = (b & c) | (b & d) | (c & d);
        k = K3;
      end
      PH_PARITY2: begin
        f = b ^ c ^ d;
        k = K4;
      end
      default: begin
        f = b ^ c ^ d;
        k = K4;
      end
    endcase
    t     = rotl5(a) + f + e + win[0] + k;
    w_new = rotl1(win[13] ^ win[8] ^ win[2] ^ win[0]);
  end

  // Chain and byte count take their reset values on reset and on clear
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      h[0]       <= IV0;
      h[1]       <= IV1;
      h[2]       <= IV2;
      h[3]       <= IV3;
      h[4]       <= IV4;
      byte_count <= '0;
    end else begin
      if (cmd.push) begin
        byte_count <= byte_count + 1'b1;
      end
      if (cmd.add) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
    end
  end

  // Pack bytes big-endian, shift whole words into the schedule window, and extend it during rounds
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      acc <= {acc[15:0], pb};
      if (byte_count[1:0] == 2'd3) begin
        for (int i = 0; i < SCHED_DEPTH - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[SCHED_DEPTH-1] <= {acc, pb};
      end
    end else if (cmd.round_en) begin
      for (int i = 0; i < SCHED_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[SCHED_DEPTH-1] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_len) begin
      len <= {byte_count, 3'b000};
    end else if (cmd.push && cmd.sel == SEL_LEN) begin
      len <= {len[55:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (cmd.round_en) begin
      a <= t;
      b <= a;
      c <= rotl30(b);
      d <= c;
      e <= d;
    end
  end

  always_comb begin
    unique case (cmd.word_sel)
      3'd0:    digest_word = h[0];
      3'd1:    digest_word = h[1];
      3'd2:    digest_word = h[2];
      3'd3:    digest_word = h[3];
      default: digest_word = h[4];
    endcase
  end

  assign status.pos = byte_count[POS_W-1:0];

endmodule

// ===== dv/tb_sha1_stream_hasher.sv =====
// Self-checking testbench for the SHA-1 stream hasher: directed rows, random messages.
module tb_sha1_stream_hasher;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  // Hold-off falls inside the second random digest: the directed rows give five digests.
  localparam int unsigned HOLD_AT_WORD = 32;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned ITEM_TARGET  = 180;
  localparam int unsigned MIN_MESSAGES = 6;
  localparam int unsigned GAP_PCT      = 22;
  localparam int unsigned NOISE_PCT    = 5;
  localparam int unsigned DRAIN_CYCLES = 20;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;
  localparam logic [31:0] RK_CH   = 32'h5a827999;
  localparam logic [31:0] RK_PAR1 = 32'h6ed9eba1;
  localparam logic [31:0] RK_MAJ  = 32'h8f1bbcdc;
  localparam logic [31:0] RK_PAR2 = 32'hca62c1d6;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam logic [5:0]  LEN_FIELD_POS = 6'd56;
  localparam logic [5:0]  BLOCK_END_POS = 6'd63;
  localparam logic [2:0]  FINAL_WORD = 3'd4;

  localparam logic [159:0] DIGEST_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] DIGEST_ABC   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  typedef struct packed {
    logic [7:0]   data;
    logic         has_byte;
    logic         ends_msg;
    logic         known;
    logic [159:0] digest;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_valid = 1'b0;
  logic        end_of_message = 1'b0;
  logic        digest_valid;
  logic        digest_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // Shadow hash state
  logic [31:0] chain [5];
  logic [7:0]  msg_block [64];
  logic [60:0] msg_len;

  digest_beat_t expected_words [$];
  digest_beat_t want;
  int unsigned  words_taken = 0;
  int unsigned  fail_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  cycle_count = 0;
  logic         src_gaps = 1'b1;
  logic         sink_gaps = 1'b1;

  // Extremes of every field, the empty message, an end beat without a byte,
  // an end riding on a byte, and ignored beats between messages.
  stim_row_t directed_rows [13] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
    '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h63, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hff, 1'b0, 1'b1, 1'b1, DIGEST_ABC},
    '{8'hff, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'h5a, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h7f, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h01, 1'b1, 1'b1, 1'b0, 160'h0}
  };

  sha1_stream_hasher u_top (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .digest_valid   (digest_valid),
    .digest_ready   (digest_ready),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void restart_chain();
    chain[0] = H0_INIT;
    chain[1] = H1_INIT;
    chain[2] = H2_INIT;
    chain[3] = H3_INIT;
    chain[4] = H4_INIT;
    msg_len = '0;
  endfunction

  // Run the 80 rounds over the current block and fold into the chain.
  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = RK_CH;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = RK_PAR1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RK_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = RK_PAR2;
      end
      t = {a[26:0], a[31:27]} + f + e + w[i] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endfunction

  // Absorb one beat; return 1 with the digest when the beat closes a message.
  function automatic bit hash_item(input logic [7:0] d, input logic bv, input logic eom,
                                   output logic [159:0] dg);
    logic [5:0]  pos;
    logic [63:0] bits;
    dg = '0;
    if (bv) begin
      pos = msg_len[5:0];
      msg_block[pos] = d;
      msg_len = msg_len + 61'd1;
      if (pos == BLOCK_END_POS) compress_block();
    end
    if (!eom) return 1'b0;
    pos = msg_len[5:0];
    msg_block[pos] = PAD_MARK;
    for (int j = int'(pos) + 1; j < 64; j++) msg_block[j] = 8'h00;
    // No room for the length field: flush and pad a fresh block.
    if (pos >= LEN_FIELD_POS) begin
      compress_block();
      for (int j = 0; j < 56; j++) msg_block[j] = 8'h00;
    end
    bits = {msg_len, 3'b000};
    for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
    compress_block();
    dg = {chain[0], chain[1], chain[2], chain[3], chain[4]};
    restart_chain();
    return 1'b1;
  endfunction

  // Offer one beat, hold it until taken, then record what it should produce.
  task automatic offer(input logic [7:0] d, input logic bv, input logic eom,
                       input logic known, input logic [159:0] known_dg);
    logic [159:0] dg;
    digest_beat_t beat;
    while (src_gaps && $urandom_range(99) < GAP_PCT) begin
      item_valid <= 1'b0;
      data_byte  <= 8'($urandom);
      @(posedge clk);
    end
    item_valid     <= 1'b1;
    data_byte      <= d;
    byte_valid     <= bv;
    end_of_message <= eom;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (bv || eom) items_sent++;
    if (hash_item(d, bv, eom, dg)) begin
      if (known) dg = known_dg;
      for (int i = 0; i < 5; i++) begin
        beat.word = dg[159-32*i -: 32];
        beat.pos  = 3'(i);
        beat.last = (3'(i) == FINAL_WORD);
        expected_words.push_back(beat);
      end
    end
  endtask

  // Mostly short messages; now and then one that lands on a padding boundary.
  function automatic int unsigned pick_length();
    int unsigned edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    if ($urandom_range(9) < 2) return edges[$urandom_range(9)];
    return $urandom_range(20);
  endfunction

  initial begin
    int unsigned msg_no;
    int unsigned len;
    bit          end_on_byte;
    restart_chain();
    for (int j = 0; j < 64; j++) msg_block[j] = 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r])
      offer(directed_rows[r].data, directed_rows[r].has_byte, directed_rows[r].ends_msg,
            directed_rows[r].known, directed_rows[r].digest);

    // Pause the source until every directed digest has drained.
    item_valid <= 1'b0;
    wait (expected_words.size() == 0);

    msg_no = 0;
    while (items_sent < ITEM_TARGET || msg_no < MIN_MESSAGES) begin
      // Run a few messages back to back with no idling on either side.
      src_gaps  <= !(msg_no inside {[3:5]});
      sink_gaps <= !(msg_no inside {[3:5]});
      len = pick_length();
      end_on_byte = (len != 0) && $urandom_range(1);
      for (int unsigned n = 0; n < len; n++) begin
        if ($urandom_range(99) < NOISE_PCT) offer(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
        offer(8'($urandom), 1'b1, end_on_byte && (n == len - 1), 1'b0, '0);
      end
      if (!end_on_byte) offer(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
      msg_no++;
    end

    item_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb_sha1_stream_hasher OK");
    else $display("tb_sha1_stream_hasher NOT OK");
    $finish;
  end

  // Digest sink: random stalls, plus one long hold-off that backs up the input.
  initial begin
    bit held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_taken >= HOLD_AT_WORD) begin
        held = 1'b1;
        digest_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      digest_ready <= !(sink_gaps && $urandom_range(99) < GAP_PCT);
    end
  end

  // Compare each taken digest beat with the oldest pending prediction.
  always @(posedge clk) begin
    if (!rst && digest_valid && digest_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected digest beat: digest_word %h word_index %0d last_word %0b",
               digest_word, word_index, last_word);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (digest_word !== want.word) begin
          $error("digest_word expected %h actual %h", want.word, digest_word);
          fail_count++;
        end
        if (word_index !== want.pos) begin
          $error("word_index expected %0d actual %0d", want.pos, word_index);
          fail_count++;
        end
        if (last_word !== want.last) begin
          $error("last_word expected %0b actual %0b", want.last, last_word);
          fail_count++;
        end
      end
      words_taken <= words_taken + 1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_sha1_stream_hasher NOT OK");
    $finish;
  end

endmodule
